>>> hdl/ssd_pkg.sv
// Shared types, constants and the segment table for the seven-segment shift driver.
package ssd_pkg;

    localparam int MAX_POSITIONS = 8;

    localparam logic       OP_LOAD    = 1'b0;
    localparam logic       OP_REFRESH = 1'b1;

    localparam logic [7:0] BLANK_POSITION0 = 8'h3E;
    localparam logic [7:0] DECIMAL_POINT   = 8'h80;
    // ceil(2^35 / 10): x * RECIP_TEN >> 35 is exact x / 10 for any 32-bit x
    localparam logic [31:0] RECIP_TEN      = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT    = 35;

    typedef struct packed {
        logic        is_refresh;
        logic [31:0] value;
    } cmd_t;

    function automatic logic [7:0] digit_segments(input logic [3:0] digit);
        logic [7:0] seg;
        begin
            unique case (digit)
                4'd0:    seg = 8'h3F;
                4'd1:    seg = 8'h06;
                4'd2:    seg = 8'h5B;
                4'd3:    seg = 8'h4F;
                4'd4:    seg = 8'h66;
                4'd5:    seg = 8'h6D;
                4'd6:    seg = 8'h7D;
                4'd7:    seg = 8'h07;
                4'd8:    seg = 8'h7F;
                4'd9:    seg = 8'h6F;
                default: seg = 8'h00;
            endcase
            return seg;
        end
    endfunction

endpackage

>>> hdl/seven_segment_mux_shift_driver.sv
// Top level of the multiplexed seven-segment driver for an external shift register.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | operation, value
//  out     | output    | out_valid/out_stall | is_latch, serial_bit, digit_enable_n, last
//
// A load item runs one divide-by-ten per cycle through a single reciprocal multiplier,
// one per position. A refresh item fetches the pattern, then gives nine results (eight
// bits, then the latch) at one per cycle from the output register while not stalled.
// A two-entry queue sits between input and execution, so input is taken while work runs.
// Reset clears the scan position, the queue and the patterns (position 0 shows 0x3E).
// An output stall holds the output register and pauses refresh shifting; input keeps filling
// the queue until it is full.
module seven_segment_mux_shift_driver
#(
    parameter int POSITIONS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_latch,
    output logic        serial_bit,
    output logic [3:0]  digit_enable_n,
    output logic        last
);
    import ssd_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    ssd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ssd_back #(.POSITIONS(POSITIONS)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_latch       (is_latch),
        .serial_bit     (serial_bit),
        .digit_enable_n (digit_enable_n),
        .last           (last)
    );

endmodule

>>> hdl/ssd_front.sv
// Input stage: accepts items, classifies them and holds them in a two-entry queue.
module ssd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [31:0]        value,
    output logic               cmd_valid,
    output ssd_pkg::cmd_t      cmd,
    input  logic               cmd_pop
);
    import ssd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    cmd_t       new_cmd;

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_cmd.is_refresh = (operation == OP_REFRESH);
        new_cmd.value      = value;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> hdl/ssd_back.sv
// Execution stage: digit extraction for loads, serial shift-out and latch for refreshes.
module ssd_back
#(
    parameter int POSITIONS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  ssd_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_latch,
    output logic               serial_bit,
    output logic [3:0]         digit_enable_n,
    output logic               last
);
    import ssd_pkg::*;

    localparam int PW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOAD  = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic [31:0] num_reg;
    logic [31:0] num_next;
    logic [7:0]  shift_reg;
    logic [7:0]  shift_next;
    logic [PW-1:0] scan_reg;
    logic [PW-1:0] scan_next;
    logic [7:0]  pattern_reg [POSITIONS];

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_is_latch_reg;
    logic        out_is_latch_next;
    logic        out_bit_reg;
    logic        out_bit_next;
    logic [3:0]  out_enable_reg;
    logic [3:0]  out_enable_next;
    logic        out_last_reg;
    logic        out_last_next;

    logic [63:0] product;
    logic [31:0] quotient;
    logic [31:0] remainder;
    logic [7:0]  load_pattern;
    logic        pattern_we;
    logic        out_free;
    logic [MAX_POSITIONS-1:0] scan_onehot;

    // divide by ten through the reciprocal; remainder selects the segment code
    assign product      = 64'(num_reg) * 64'(RECIP_TEN);
    assign quotient     = 32'(product >> RECIP_SHIFT);
    assign remainder    = num_reg - ((quotient << 3) + (quotient << 1));
    assign load_pattern = digit_segments(remainder[3:0])
                        | ((cnt_reg == 4'(POSITIONS - 1)) ? DECIMAL_POINT : 8'h00);
    assign pattern_we   = (state_reg == S_LOAD) && (cnt_reg != 4'd0);

    assign scan_onehot  = MAX_POSITIONS'(1) << scan_reg;
    assign out_free     = !out_valid_reg || !out_stall;
    assign cmd_pop      = (state_reg == S_IDLE) && cmd_valid;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        num_next          = num_reg;
        shift_next        = shift_reg;
        scan_next         = scan_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_is_latch_next = out_is_latch_reg;
        out_bit_next      = out_bit_reg;
        out_enable_next   = out_enable_reg;
        out_last_next     = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = 4'd0;
                if (cmd_valid)
                begin
                    if (cmd.is_refresh)
                    begin
                        shift_next = pattern_reg[scan_reg];
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        num_next   = cmd.value;
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                num_next = quotient;
                if (cnt_reg == 4'(POSITIONS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_SHIFT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (cnt_reg == 4'd8)
                    begin
                        out_is_latch_next = 1'b1;
                        out_bit_next      = 1'b0;
                        out_enable_next   = ~scan_onehot[3:0];
                        out_last_next     = 1'b1;
                        scan_next  = (scan_reg == PW'(POSITIONS - 1)) ? '0 : scan_reg + PW'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_is_latch_next = 1'b0;
                        out_bit_next      = shift_reg[7];
                        out_enable_next   = 4'hF;
                        out_last_next     = 1'b0;
                        shift_next        = {shift_reg[6:0], 1'b0};
                        cnt_next          = cnt_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 4'd0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < POSITIONS; p++)
            begin
                pattern_reg[p] <= (p == 0) ? BLANK_POSITION0 : 8'h00;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (pattern_we)
            begin
                pattern_reg[cnt_reg[PW-1:0]] <= load_pattern;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg          <= num_next;
        shift_reg        <= shift_next;
        out_is_latch_reg <= out_is_latch_next;
        out_bit_reg      <= out_bit_next;
        out_enable_reg   <= out_enable_next;
        out_last_reg     <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign is_latch       = out_is_latch_reg;
    assign serial_bit     = out_bit_reg;
    assign digit_enable_n = out_enable_reg;
    assign last           = out_last_reg;

    a_last_is_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == out_is_latch_reg))
        else $error("last flag does not match latch result");

    a_shift_all_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_is_latch_reg) |-> (out_enable_reg == 4'hF))
        else $error("digit enabled during shift pulse");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (cnt_reg <= 4'(POSITIONS - 1)))
        else $error("load digit count out of range");

    a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (cnt_reg <= 4'd8))
        else $error("shift count out of range");

endmodule
